// ===== sv/ssca_pkg.sv =====
// Shared types and constants for the seven-sensor cross-section area core.
// No dependencies.
package ssca_pkg;

  localparam int NUM_SENSORS = 7;
  localparam int DIST_W      = 17;
  localparam int VALUE_W     = 44;

  localparam logic [1:0] KIND_FAULT = 2'd0;
  localparam logic [1:0] KIND_DIST  = 2'd1;
  localparam logic [1:0] KIND_AREA  = 2'd2;

  localparam logic [2:0] CFG_OUTPUT_MODE = 3'd0;

  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [NUM_SENSORS-1:0][DIST_W-1:0] dists;
  } cmd_t;

  function automatic logic [7:0] offset_reset(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd20;
      3'd1:    v = 8'd15;
      3'd2:    v = 8'd12;
      3'd3:    v = 8'd9;
      3'd4:    v = 8'd8;
      3'd5:    v = 8'd13;
      default: v = 8'd20;
    endcase
    return v;
  endfunction

  // Q1.16 cosines of the fan angles
  function automatic logic [16:0] cos_q16(input logic [2:0] idx);
    logic [16:0] v;
    case (idx)
      3'd0, 3'd6: v = 17'd52429;
      3'd1, 3'd5: v = 17'd58615;
      3'd2, 3'd4: v = 17'd63577;
      default:    v = 17'd65536;
    endcase
    return v;
  endfunction

  // Q1.16 sines of the fan angles
  function automatic logic [16:0] sin_q16(input logic [2:0] idx);
    logic [16:0] v;
    case (idx)
      3'd0, 3'd6: v = 17'd39322;
      3'd1, 3'd5: v = 17'd29314;
      3'd2, 3'd4: v = 17'd15899;
      default:    v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ssca_front.sv =====
// Front end: configuration registers, per-sensor distance store, frame and
// fault bookkeeping; at most one command per closed frame. Uses ssca_pkg.
module ssca_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_sensor_index,
  input  logic [15:0]         in_raw_reading,
  input  logic                in_read_failed,
  input  logic                q_full,
  output logic                q_push,
  output ssca_pkg::cmd_t      q_push_data
);

  logic                  mode_r;
  logic [7:0]            off_r [ssca_pkg::NUM_SENSORS];
  ssca_pkg::dist_t       dist_r [ssca_pkg::NUM_SENSORS];
  logic                  fail_r, fail_nxt;
  logic                  reported_r, reported_nxt;
  logic                  accept;
  logic                  valid_idx;
  ssca_pkg::dist_t       dist_new;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign valid_idx = (in_sensor_index != 3'd7);
  assign dist_new  = in_read_failed ? '0 :
                     (17'(in_raw_reading) + 17'd16 + 17'(off_r[in_sensor_index]));

  always_comb begin
    fail_nxt     = fail_r;
    reported_nxt = reported_r;
    q_push       = 1'b0;
    q_push_data.kind = ssca_pkg::KIND_FAULT;
    for (int i = 0; i < ssca_pkg::NUM_SENSORS; i++) begin
      q_push_data.dists[i] = dist_r[i];
    end
    q_push_data.dists[6] = dist_new;
    if (accept && valid_idx) begin
      if (in_read_failed) begin
        fail_nxt = 1'b1;
      end
      if (in_sensor_index == 3'd6) begin
        if (fail_r || in_read_failed) begin
          fail_nxt = 1'b0;
          if (!reported_r) begin
            reported_nxt     = 1'b1;
            q_push           = 1'b1;
            q_push_data.kind = ssca_pkg::KIND_FAULT;
          end
        end else begin
          reported_nxt     = 1'b0;
          q_push           = 1'b1;
          q_push_data.kind = mode_r ? ssca_pkg::KIND_DIST : ssca_pkg::KIND_AREA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      fail_r     <= 1'b0;
      reported_r <= 1'b0;
      for (int i = 0; i < ssca_pkg::NUM_SENSORS; i++) begin
        off_r[i]  <= ssca_pkg::offset_reset(3'(i));
        dist_r[i] <= '0;
      end
    end else begin
      fail_r     <= fail_nxt;
      reported_r <= reported_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == ssca_pkg::CFG_OUTPUT_MODE) begin
          mode_r <= cfg_wdata[0];
        end else begin
          off_r[cfg_index - 3'd1] <= cfg_wdata;
        end
      end
      if (accept && valid_idx) begin
        dist_r[in_sensor_index] <= dist_new;
      end
    end
  end

  a_push_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (accept && in_sensor_index == 3'd6))
    else $error("push without frame close");
  a_fault_once: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_push_data.kind == ssca_pkg::KIND_FAULT) |-> !reported_r)
    else $error("fault pushed twice");

endmodule

// ===== sv/ssca_queue.sv =====
// Two-entry command queue between front and back end. Uses ssca_pkg.
module ssca_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ssca_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ssca_pkg::cmd_t pop_data
);

  ssca_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("queue underflow");

endmodule

// ===== sv/ssca_back.sv =====
// Back end: sequencer around one shared multiplier and a bit-serial divider;
// computes the cross-section area and holds the result register. Uses ssca_pkg.
module ssca_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ssca_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [43:0]    out_value,
  output logic           out_fault
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_SDM   = 4'd2;
  localparam logic [3:0] S_SDC   = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SLOPE = 4'd6;
  localparam logic [3:0] S_HC    = 4'd7;
  localparam logic [3:0] S_HM1   = 4'd8;
  localparam logic [3:0] S_HM2   = 4'd9;
  localparam logic [3:0] S_HF    = 4'd10;
  localparam logic [3:0] S_TA    = 4'd11;
  localparam logic [3:0] S_TB    = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam logic [5:0] DIV_LAST = 6'd48;

  logic [3:0]          state_r, state_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [5:0]          dcnt_r, dcnt_nxt;
  ssca_pkg::dist_t     d_r [ssca_pkg::NUM_SENSORS];
  logic signed [64:0]  p_r, p_nxt;
  logic signed [34:0]  mul_a;
  logic signed [29:0]  mul_b;
  logic signed [37:0]  h0_r, h0_nxt;
  logic signed [37:0]  num_r, num_nxt;
  logic [33:0]         den_r, den_nxt;
  logic [31:0]         sdprev_r, sdprev_nxt;
  logic [31:0]         gap_r [6];
  logic [31:0]         gap_val;
  logic [34:0]         cum_r, cum_nxt;
  logic signed [18:0]  slope_r, slope_nxt;
  logic signed [37:0]  rq_r, rq_nxt;
  logic [36:0]         h_r [ssca_pkg::NUM_SENSORS];
  logic [36:0]         h_val;
  logic [36:0]         hprev_r, hprev_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [33:0]         rem_r, rem_nxt;
  logic [48:0]         quo_r, quo_nxt;
  logic [48:0]         nsh_r, nsh_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [43:0]         out_value_r, out_value_nxt;
  logic                out_fault_r, out_fault_nxt;

  logic signed [17:0]  dsum_diff;
  logic [17:0]         dsum;
  logic [31:0]         num_abs;
  logic [33:0]         rem_sh;
  logic [64:0]         p_abs;
  logic [48:0]         p_rnd;
  logic signed [37:0]  h_diff;
  logic signed [32:0]  sd_diff;
  logic [36:0]         h_cur;
  logic [37:0]         h_step;
  logic [39:0]         t17;
  logic [30:0]         t8;
  logic [63:0]         acc_rnd;

  assign dsum_diff = signed'({1'b0, d_r[0]}) - signed'({1'b0, d_r[6]});
  assign dsum      = {1'b0, d_r[0]} + {1'b0, d_r[6]};
  assign h_cur     = h_r[k_r + 3'd1];
  assign h_step    = (h_cur >= hprev_r) ? 38'(h_cur - hprev_r) : 38'(hprev_r - h_cur);
  assign t17       = {2'b0, hprev_r, 1'b0} + 40'(h_step);
  assign t8        = 31'((t17 + 40'd256) >> 9);
  assign acc_rnd   = acc_r + 64'd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PRE: begin
        case (k_r)
          3'd0: begin
            mul_a = 35'(signed'({1'b0, d_r[0]}));
            mul_b = 30'(signed'({1'b0, ssca_pkg::cos_q16(3'd0)}));
          end
          3'd1: begin
            mul_a = 35'(dsum_diff);
            mul_b = 30'(signed'({1'b0, ssca_pkg::cos_q16(3'd0)}));
          end
          3'd2: begin
            mul_a = 35'(signed'({1'b0, dsum}));
            mul_b = 30'(signed'({1'b0, ssca_pkg::sin_q16(3'd0)}));
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_SDM: begin
        mul_a = 35'(signed'({1'b0, d_r[k_r]}));
        mul_b = 30'(signed'({1'b0, ssca_pkg::sin_q16(k_r)}));
      end
      S_HM1: begin
        mul_a = signed'(cum_r);
        mul_b = 30'(slope_r);
      end
      S_HM2: begin
        mul_a = 35'(signed'({1'b0, d_r[k_r]}));
        mul_b = 30'(signed'({1'b0, ssca_pkg::cos_q16(k_r)}));
      end
      S_TA: begin
        mul_a = 35'(signed'({1'b0, gap_r[k_r]}));
        mul_b = signed'({1'b0, t8[28:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_nxt = 65'(mul_a) * 65'(mul_b);

  always_comb begin
    num_abs = num_r[37] ? 32'(-num_r) : num_r[31:0];
    rem_sh  = {rem_r[32:0], nsh_r[48]};
    p_abs   = p_r[64] ? 65'(-p_r) : 65'(p_r);
    p_rnd   = 49'((p_abs + 65'd32768) >> 16);
    sd_diff = signed'({1'b0, sdprev_r}) - signed'({1'b0, p_r[31:0]});
    gap_val = sd_diff[32] ? 32'(-sd_diff) : sd_diff[31:0];
    h_diff  = h0_r - rq_r - p_r[37:0];
    h_val   = h_diff[37] ? 37'(-h_diff) : h_diff[36:0];
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    dcnt_nxt      = dcnt_r;
    h0_nxt        = h0_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    sdprev_nxt    = sdprev_r;
    cum_nxt       = cum_r;
    slope_nxt     = slope_r;
    rq_nxt        = rq_r;
    hprev_nxt     = hprev_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    nsh_nxt       = nsh_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fault_nxt = out_fault_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop = 1'b1;
          case (q_data.kind)
            ssca_pkg::KIND_FAULT: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_fault_nxt = 1'b1;
            end
            ssca_pkg::KIND_DIST: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = 44'({q_data.dists[3], 8'd0});
              out_fault_nxt = 1'b0;
            end
            default: begin
              state_nxt = S_PRE;
              k_nxt     = 3'd0;
            end
          endcase
        end
      end
      S_PRE: begin
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd1: h0_nxt = p_r[37:0];
          3'd2: num_nxt = p_r[37:0];
          3'd3: begin
            den_nxt   = p_r[33:0];
            state_nxt = S_SDM;
            k_nxt     = 3'd0;
          end
          default: ;
        endcase
      end
      S_SDM: state_nxt = S_SDC;
      S_SDC: begin
        sdprev_nxt = p_r[31:0];
        if (k_r == 3'd6) begin
          state_nxt = S_DINIT;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_SDM;
        end
      end
      S_DINIT: begin
        rem_nxt   = '0;
        quo_nxt   = '0;
        nsh_nxt   = {1'b0, num_abs, 16'd0} + 49'(den_r >> 1);
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        nsh_nxt  = {nsh_r[47:0], 1'b0};
        dcnt_nxt = dcnt_r + 6'd1;
        if (rem_sh >= den_r) begin
          rem_nxt = rem_sh - den_r;
          quo_nxt = {quo_r[47:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[47:0], 1'b0};
        end
        if (dcnt_r == DIV_LAST) begin
          state_nxt = S_SLOPE;
        end
      end
      S_SLOPE: begin
        if (den_r == '0) begin
          slope_nxt = '0;
        end else if (num_r[37]) begin
          slope_nxt = -signed'({1'b0, quo_r[17:0]});
        end else begin
          slope_nxt = signed'({1'b0, quo_r[17:0]});
        end
        cum_nxt   = '0;
        k_nxt     = 3'd0;
        state_nxt = S_HM1;
      end
      S_HC: begin
        cum_nxt   = cum_r + 35'(gap_r[k_r - 3'd1]);
        state_nxt = S_HM1;
      end
      S_HM1: state_nxt = S_HM2;
      S_HM2: begin
        rq_nxt    = p_r[64] ? -signed'(38'(p_rnd)) : signed'(38'(p_rnd));
        state_nxt = S_HF;
      end
      S_HF: begin
        if (k_r == 3'd0) begin
          hprev_nxt = h_val;
        end
        if (k_r == 3'd6) begin
          acc_nxt   = '0;
          k_nxt     = 3'd0;
          state_nxt = S_TA;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_HC;
        end
      end
      S_TA: begin
        hprev_nxt = h_cur;
        state_nxt = S_TB;
      end
      S_TB: begin
        acc_nxt = acc_r + p_r[63:0];
        if (k_r == 3'd5) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_TA;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = 1'b0;
          out_value_nxt = (acc_rnd[63:60] != 4'd0) ? '1 : acc_rnd[59:16];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    dcnt_r      <= dcnt_nxt;
    p_r         <= p_nxt;
    h0_r        <= h0_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    sdprev_r    <= sdprev_nxt;
    cum_r       <= cum_nxt;
    slope_r     <= slope_nxt;
    rq_r        <= rq_nxt;
    hprev_r     <= hprev_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    nsh_r       <= nsh_nxt;
    out_value_r <= out_value_nxt;
    out_fault_r <= out_fault_nxt;
    if (q_pop) begin
      for (int i = 0; i < ssca_pkg::NUM_SENSORS; i++) begin
        d_r[i] <= q_data.dists[i];
      end
    end
    if (state_r == S_SDC && k_r != 3'd0) begin
      gap_r[k_r - 3'd1] <= gap_val;
    end
    if (state_r == S_HF) begin
      h_r[k_r] <= h_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_fault = out_fault_r;

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_value_r == '0))
    else $error("fault item with nonzero value");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && !out_valid_r))
    else $error("command taken while busy");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dcnt_r <= DIV_LAST))
    else $error("divider overran");

endmodule

// ===== sv/seven_sensor_cross_section_area_core.sv =====
// Top level of the seven-sensor cross-section area core.
// Instantiates ssca_front, ssca_queue and ssca_back; uses ssca_pkg.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | sensor_index, raw_reading, read_failed
//   out_    | output    | out_valid/out_ready | result_value, is_fault
//   cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// Readings are taken one per cycle while the command queue is not full;
// only the frame-closing item queues work. An area frame runs in the back
// end through the shared multiplier sequence and the 49-step serial divider;
// fault and distance results are registered from idle. Reset is synchronous,
// active low. in_ready drops only while the two-entry command queue is full.
module seven_sensor_cross_section_area_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_sensor_index,
  input  logic [15:0] in_raw_reading,
  input  logic        in_read_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [43:0] out_result_value,
  output logic        out_is_fault
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  ssca_pkg::cmd_t q_push_data;
  ssca_pkg::cmd_t q_pop_data;

  ssca_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sensor_index (in_sensor_index),
    .in_raw_reading  (in_raw_reading),
    .in_read_failed  (in_read_failed),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  ssca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  ssca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_result_value),
    .out_fault (out_is_fault)
  );

endmodule

// ===== tb/seven_sensor_cross_section_area_core_tb.sv =====
// Testbench for seven_sensor_cross_section_area_core: random and directed frames,
// a bit-exact area/distance predictor and an in-order result check.
// Depends on ssca_pkg and the core RTL.
module seven_sensor_cross_section_area_core_tb;

  localparam logic [2:0] REG_MODE = ssca_pkg::CFG_OUTPUT_MODE;
  localparam logic [2:0] REG_OFS0 = 3'd1;
  localparam logic [43:0] VAL_MAX = {44{1'b1}};

  typedef struct {
    logic [2:0]  idx;
    logic [15:0] raw;
    logic        failed;
  } reading_t;

  typedef struct {
    logic [43:0] value;
    logic        fault;
  } report_t;

  logic        clk, rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid, in_ready;
  logic [2:0]  in_sensor_index;
  logic [15:0] in_raw_reading;
  logic        in_read_failed;
  logic        out_valid, out_ready;
  logic [43:0] out_result_value;
  logic        out_is_fault;

  seven_sensor_cross_section_area_core i_dut (.*);

  reading_t pending_readings[$];
  report_t  expected_reports[$];
  int       errors = 0;
  bit       rx_hold = 0;
  bit       tx_pause = 0;
  bit       in_taken = 0;

  // predictor state
  logic [16:0] dist_m[7];
  bit          frame_bad, fault_sent;
  bit          mode_m;
  logic [7:0]  offs_m[7];

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd16(longint v);
    longint r;
    r = (iabs(v) + 32768) >>> 16;
    return v < 0 ? -r : r;
  endfunction

  function automatic longint cs(int k);
    return (k == 0 || k == 6) ? 52429 : (k == 1 || k == 5) ? 58615 :
           (k == 2 || k == 4) ? 63577 : 65536;
  endfunction

  function automatic longint sn(int k);
    return (k == 0 || k == 6) ? 39322 : (k == 1 || k == 5) ? 29314 :
           (k == 2 || k == 4) ? 15899 : 0;
  endfunction

  function automatic logic [63:0] area_q8();
    longint d[7], gap[6], h[7];
    longint cum, slope, num, den, h0, q;
    logic [63:0] acc, t17, t8;
    cum = 0; slope = 0; acc = 0;
    for (int k = 0; k < 7; k++) d[k] = dist_m[k];
    h0 = cs(0) * d[0];
    num = cs(0) * (d[0] - d[6]);
    den = sn(0) * (d[0] + d[6]);
    if (den != 0) begin
      q = ((iabs(num) << 16) + den / 2) / den;
      slope = num < 0 ? -q : q;
    end
    for (int k = 0; k < 6; k++) gap[k] = iabs(d[k] * sn(k) - d[k+1] * sn(k+1));
    for (int k = 0; k < 7; k++) begin
      if (k > 0) cum += gap[k-1];
      h[k] = iabs(h0 - rnd16(cum * slope) - cs(k) * d[k]);
    end
    for (int k = 0; k < 6; k++) begin
      t17 = 2 * h[k] + iabs(h[k+1] - h[k]);
      t8 = (t17 + 256) >> 9;
      acc += gap[k] * t8;
    end
    return (acc + 32768) >> 16;
  endfunction

  function automatic void predict_frame(reading_t r);
    report_t rep;
    logic [63:0] v;
    if (r.idx > 6) return;
    dist_m[r.idx] = r.failed ? 17'd0 : 17'(r.raw) + 17'd16 + 17'(offs_m[r.idx]);
    if (r.failed) frame_bad = 1;
    if (r.idx != 6) return;
    if (frame_bad) begin
      frame_bad = 0;
      if (fault_sent) return;
      fault_sent = 1;
      rep.value = '0; rep.fault = 1;
      expected_reports.push_back(rep);
      return;
    end
    fault_sent = 0;
    v = mode_m ? (64'(dist_m[3]) << 8) : area_q8();
    rep.value = v > VAL_MAX ? VAL_MAX : v[43:0];
    rep.fault = 0;
    expected_reports.push_back(rep);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    return p < 60 ? 0 : p < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // driver
  int tx_wait = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_taken) begin
    end else if (tx_wait > 0) begin
      tx_wait <= tx_wait - 1;
      in_valid <= 0;
    end else if (pending_readings.size() > 0 && !tx_pause) begin
      reading_t r;
      r = pending_readings.pop_front();
      in_valid <= 1;
      in_sensor_index <= r.idx;
      in_raw_reading <= r.raw;
      in_read_failed <= r.failed;
      tx_wait <= gap_len();
    end else begin
      in_valid <= 0;
    end
  end

  always @(posedge clk)
    in_taken <= rst_n && in_valid && in_ready;

  always @(posedge clk)
    if (rst_n && in_valid && in_ready)
      predict_frame('{in_sensor_index, in_raw_reading, in_read_failed});

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (rx_hold) out_ready <= 0;
    else out_ready <= gap_len() == 0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result value=%0h fault=%0b", out_result_value, out_is_fault);
        errors++;
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        if (out_result_value !== e.value) begin
          $error("result_value expected %0h actual %0h", e.value, out_result_value);
          errors++;
        end
        if (out_is_fault !== e.fault) begin
          $error("is_fault expected %0b actual %0b", e.fault, out_is_fault);
          errors++;
        end
      end
    end
  end

  function automatic reading_t mk(int idx, int raw, bit f);
    reading_t r;
    r.idx = 3'(idx); r.raw = 16'(raw); r.failed = f;
    return r;
  endfunction

  function automatic int rand_raw();
    int p;
    p = $urandom_range(0, 9);
    return p < 5 ? $urandom_range(0, 400) : p < 7 ? $urandom_range(0, 65535) :
           p < 8 ? 65535 - $urandom_range(0, 3) : $urandom_range(0, 3);
  endfunction

  task automatic push_frame(bit noisy);
    for (int k = 0; k < 7; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) continue;
      if (noisy && $urandom_range(0, 19) == 0)
        pending_readings.push_back(mk(7, $urandom_range(0, 65535),
                                      1'($urandom_range(0, 1))));
      pending_readings.push_back(mk(noisy && $urandom_range(0, 7) == 0 ?
                                    $urandom_range(0, 6) : k,
                                    rand_raw(), $urandom_range(0, 24) == 0));
    end
  endtask

  task automatic wait_drained();
    while (pending_readings.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    if (idx == REG_MODE) mode_m = v[0];
    else offs_m[idx - 3'd1] = v;
  endtask

  initial begin
    rst_n = 0; cfg_wr_en = 0; cfg_index = 0; cfg_wdata = 0;
    in_valid = 0; in_sensor_index = 0; in_raw_reading = 0; in_read_failed = 0;
    out_ready = 0;
    for (int k = 0; k < 7; k++) dist_m[k] = 0;
    frame_bad = 0; fault_sent = 0; mode_m = 0;
    offs_m = '{20, 15, 12, 9, 8, 13, 20};
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: zero baseline, extremes, ignored index, repeated faults
    for (int k = 0; k < 7; k++) pending_readings.push_back(mk(k, 0, 1));
    for (int k = 0; k < 7; k++) pending_readings.push_back(mk(k, 0, k == 3));
    for (int k = 0; k < 7; k++) pending_readings.push_back(mk(k, 65535, 0));
    pending_readings.push_back(mk(7, 16'hAAAA, 1));
    pending_readings.push_back(mk(6, 16'h5555, 0));
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_MODE, 8'(phase % 2));
      for (int k = 0; k < 7; k++)
        write_reg(3'(REG_OFS0 + k), phase == 2 ? 8'd255 : phase == 3 ? 8'd0 :
                  8'($urandom_range(0, 255)));
      if (phase == 1) begin
        rx_hold = 1;
        for (int f = 0; f < 6; f++) push_frame(0);
        repeat (600) @(posedge clk);
        rx_hold = 0;
      end
      for (int f = 0; f < 45; f++) push_frame(f % 5 == 4);
      if (phase == 3) begin
        while (pending_readings.size() > 150) @(posedge clk);
        tx_pause = 1;
        while (in_valid || expected_reports.size() > 0) @(posedge clk);
        tx_pause = 0;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("** seven_sensor_cross_section_area_core: PASSED **");
    else
      $display("** seven_sensor_cross_section_area_core: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** seven_sensor_cross_section_area_core: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/ssca_pkg.sv
sv/ssca_front.sv
sv/ssca_queue.sv
sv/ssca_back.sv
sv/seven_sensor_cross_section_area_core.sv
tb/seven_sensor_cross_section_area_core_tb.sv
